/* rtl/core/ilie_pkg.sv */
// package for the indexed list insert/erase unit
// sizes, operation and status codes, and the command bundle sent to the cell row
// no dependencies
`default_nettype none

package ilie_pkg;

   localparam int DEPTH      = 256;
   localparam int ELEM_WIDTH = 32;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_PORT_W = 9;
   localparam int STATUS_W = 2;

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W   = (COUNT_W > INDEX_W + 1) ? COUNT_W : INDEX_W + 1;

   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_OVERWRITE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ERASE     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                  write;
      logic                  shift_up;
      logic                  shift_down;
      logic                  read;
      logic [CMP_W-1:0]      pos;
      logic [ELEM_WIDTH-1:0] data;
   } ilie_cmd_type;

endpackage

`default_nettype wire

/* rtl/core/ilie_cell.sv */
// one storage cell of the element row
// depends on ilie_pkg
`default_nettype none

module ilie_cell
   import ilie_pkg::*;
(
   input  wire logic                  clock,
   input  wire ilie_cmd_type          cmd,
   input  wire logic [CMP_W-1:0]      position,
   input  wire logic [ELEM_WIDTH-1:0] prev_data,
   input  wire logic [ELEM_WIDTH-1:0] next_data,
   output logic      [ELEM_WIDTH-1:0] data,
   output logic      [ELEM_WIDTH-1:0] sel
);

   logic [ELEM_WIDTH-1:0] data_ff, data_in;
   logic [ELEM_WIDTH-1:0] sel_ff, sel_in;
   logic                  hit;

   assign hit = (position == cmd.pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up && (position > cmd.pos)) begin
         data_in = prev_data;
      end else if (cmd.shift_down && (position >= cmd.pos)) begin
         data_in = next_data;
      end
      if (cmd.write && hit) begin
         data_in = cmd.data;
      end
      sel_in = (cmd.read && hit) ? data_ff : '0;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      sel_ff  <= sel_in;
   end

   assign data = data_ff;
   assign sel  = sel_ff;

endmodule

`default_nettype wire

/* rtl/core/ilie_chain.sv */
// row of storage cells, each linked to its neighbors
// depends on ilie_pkg and ilie_cell
`default_nettype none

module ilie_chain
   import ilie_pkg::*;
(
   input  wire logic                  clock,
   input  wire ilie_cmd_type          cmd,
   output logic      [ELEM_WIDTH-1:0] sel [DEPTH]
);

   logic [ELEM_WIDTH-1:0] data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] prev_data, next_data;
      if (i == 0) begin : g_first
         assign prev_data = '0;
      end else begin : g_prev
         assign prev_data = data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_data = '0;
      end else begin : g_next
         assign next_data = data[i+1];
      end
      ilie_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .position  (CMP_W'(i)),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (data[i]),
         .sel       (sel[i])
      );
   end

endmodule

`default_nettype wire

/* rtl/core/ilie_or_tree.sv */
// two-level registered or tree that gathers the selected cell's data
// depends on ilie_pkg
`default_nettype none

module ilie_or_tree
   import ilie_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [ELEM_WIDTH-1:0] sel [DEPTH],
   output logic      [ELEM_WIDTH-1:0] data
);

   logic [ELEM_WIDTH-1:0] group_ff [NUM_GROUPS];
   logic [ELEM_WIDTH-1:0] group_in [NUM_GROUPS];
   logic [ELEM_WIDTH-1:0] data_ff, data_in;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < DEPTH) begin
               group_in[g] = group_in[g] | sel[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      data_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         data_in = data_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* rtl/core/indexed_list_insert_erase_unit.sv */
// indexed list with append, read, overwrite, insert, erase and clear on a cell row
// result path from request beat to result valid, each step registered: cell select, group or, final or
// one request at a time; a new request is taken once the result beat is gone
// every shift happens in the single cycle of the request beat, across all cells at once
// reset: synchronous, clears the element count and the pipeline; cell contents are kept
// depends on ilie_pkg, ilie_chain, ilie_or_tree
`default_nettype none

module indexed_list_insert_erase_unit
   import ilie_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [INDEX_W-1:0]      req_index,
   input  wire logic [VALUE_W-1:0]      req_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [VALUE_W-1:0]      rsp_read_value,
   output logic      [COUNT_PORT_W-1:0] rsp_count,
   output logic                         rsp_is_empty,
   output logic      [STATUS_W-1:0]     rsp_status
);

   logic [CMP_W-1:0]    count_ff, count_in;
   logic                s1_ff, s1_in, s2_ff, s2_in, out_ff, out_in;
   logic [CMP_W-1:0]    s1_count_ff, s2_count_ff, out_count_ff;
   logic [STATUS_W-1:0] s1_status_ff, s2_status_ff, out_status_ff;
   logic [STATUS_W-1:0] status;
   logic                accept;
   logic [CMP_W-1:0]    idx;
   logic                idx_ge, idx_gt, full;
   ilie_cmd_type        cmd;
   logic [ELEM_WIDTH-1:0] sel [DEPTH];
   logic [ELEM_WIDTH-1:0] tree_data;
   logic [ELEM_WIDTH+VALUE_W-1:0] value_wide;
   logic [VALUE_W+ELEM_WIDTH-1:0] read_wide;

   assign accept    = req_valid && req_ready;
   assign req_ready = !(s1_ff || s2_ff || out_ff);
   assign idx       = CMP_W'(req_index);
   assign idx_ge    = (idx >= count_ff);
   assign idx_gt    = (idx > count_ff);
   assign full      = (count_ff == CMP_W'(DEPTH));
   assign value_wide = {{ELEM_WIDTH{1'b0}}, req_value};

   always_comb begin
      status         = STATUS_OK;
      count_in       = count_ff;
      cmd.write      = 1'b0;
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.read       = 1'b0;
      cmd.pos        = idx;
      cmd.data       = value_wide[ELEM_WIDTH-1:0];
      case (req_func)
         FUNC_APPEND: begin
            cmd.pos = count_ff;
            if (full) begin
               status = STATUS_FULL;
            end else begin
               cmd.write = accept;
               count_in  = count_ff + CMP_W'(1);
            end
         end
         FUNC_READ: begin
            if (idx_ge) begin
               status = STATUS_RANGE;
            end else begin
               cmd.read = accept;
            end
         end
         FUNC_OVERWRITE: begin
            if (idx_ge) begin
               status = STATUS_RANGE;
            end else begin
               cmd.write = accept;
            end
         end
         FUNC_INSERT: begin
            if (idx_gt) begin
               status = STATUS_RANGE;
            end else if (full) begin
               status = STATUS_FULL;
            end else begin
               cmd.write    = accept;
               cmd.shift_up = accept;
               count_in     = count_ff + CMP_W'(1);
            end
         end
         FUNC_ERASE: begin
            if (idx_ge) begin
               status = STATUS_RANGE;
            end else begin
               cmd.shift_down = accept;
               count_in       = count_ff - CMP_W'(1);
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s1_in  = accept;
      s2_in  = s1_ff;
      out_in = out_ff;
      if (s2_ff) begin
         out_in = 1'b1;
      end else if (out_ff && rsp_ready) begin
         out_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
         out_ff   <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_count_ff  <= count_in;
         s1_status_ff <= status;
      end
      s2_count_ff  <= s1_count_ff;
      s2_status_ff <= s1_status_ff;
      if (s2_ff) begin
         out_count_ff  <= s2_count_ff;
         out_status_ff <= s2_status_ff;
      end
   end

   ilie_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .sel   (sel)
   );

   ilie_or_tree u_tree (
      .clock (clock),
      .load  (s2_ff),
      .sel   (sel),
      .data  (tree_data)
   );

   assign read_wide      = {{VALUE_W{1'b0}}, tree_data};
   assign rsp_valid      = out_ff;
   assign rsp_read_value = read_wide[VALUE_W-1:0];
   assign rsp_count      = COUNT_PORT_W'(out_count_ff);
   assign rsp_is_empty   = (out_count_ff == '0);
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

/* rtl/core/ilie_checker.sv */
// port-level checks for the indexed list unit, bound to the top level
// depends on ilie_pkg and indexed_list_insert_erase_unit
`default_nettype none

module ilie_checker
   import ilie_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [VALUE_W-1:0]      rsp_read_value,
   input wire logic [COUNT_PORT_W-1:0] rsp_count,
   input wire logic                    rsp_is_empty,
   input wire logic [STATUS_W-1:0]     rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_RANGE
         || rsp_status == STATUS_FULL))
      else $error("unknown status code");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_read_value == '0))
      else $error("read data on a failed request");

endmodule

bind indexed_list_insert_erase_unit ilie_checker u_checker (.*);

`default_nettype wire

/* dv/indexed_list_insert_erase_unit_tb.sv */
`timescale 1ns / 1ps
// testbench for indexed_list_insert_erase_unit: directed and random list requests,
// scoreboard predicts each result beat; depends on ilie_pkg and the unit rtl
module indexed_list_insert_erase_unit_tb;
   import ilie_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
   localparam int ITEMS_PER_PHASE = 400;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_type;

   typedef struct {
      logic [VALUE_W-1:0]      read_value;
      logic [COUNT_PORT_W-1:0] count;
      logic                    is_empty;
      logic [STATUS_W-1:0]     status;
   } list_rsp_type;

   class list_scoreboard;
      logic [ELEM_WIDTH-1:0] cells [DEPTH];
      int fill;
      list_rsp_type pending_rsp [$];
      int errors;
      int requests;
      int results;
      int n_range;
      int n_full;
      int n_full_reached;

      function new();
         fill = 0;
         errors = 0;
         requests = 0;
         results = 0;
         n_range = 0;
         n_full = 0;
         n_full_reached = 0;
      endfunction

      function void note_request(input logic [FUNC_W-1:0] func,
                                 input logic [INDEX_W-1:0] index,
                                 input logic [VALUE_W-1:0] value);
         list_rsp_type rsp;
         int idx;
         int prev_fill;
         idx = int'(index);
         prev_fill = fill;
         rsp.read_value = '0;
         rsp.status = STATUS_OK;
         case (func)
            FUNC_APPEND: begin
               if (fill >= DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  cells[fill] = ELEM_WIDTH'(value);
                  fill++;
               end
            end
            FUNC_READ: begin
               if (idx >= fill) rsp.status = STATUS_RANGE;
               else rsp.read_value = VALUE_W'(cells[idx]);
            end
            FUNC_OVERWRITE: begin
               if (idx >= fill) rsp.status = STATUS_RANGE;
               else cells[idx] = ELEM_WIDTH'(value);
            end
            FUNC_INSERT: begin
               // index check comes before the full check
               if (idx > fill) begin
                  rsp.status = STATUS_RANGE;
               end else if (fill >= DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  for (int k = fill; k > idx; k--) cells[k] = cells[k-1];
                  cells[idx] = ELEM_WIDTH'(value);
                  fill++;
               end
            end
            FUNC_ERASE: begin
               if (idx >= fill) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  for (int k = idx; k + 1 < fill; k++) cells[k] = cells[k+1];
                  fill--;
               end
            end
            FUNC_CLEAR: fill = 0;
            default: ;
         endcase
         rsp.count = COUNT_PORT_W'(fill);
         rsp.is_empty = (fill == 0);
         if (rsp.status == STATUS_RANGE) n_range++;
         if (rsp.status == STATUS_FULL) n_full++;
         if (fill == DEPTH && prev_fill != DEPTH) n_full_reached++;
         requests++;
         pending_rsp.push_back(rsp);
      endfunction

      function void report(input string field, input longint unsigned want,
                           input longint unsigned got);
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      endfunction

      function void check_response(input logic [VALUE_W-1:0] read_value,
                                   input logic [COUNT_PORT_W-1:0] count,
                                   input logic is_empty,
                                   input logic [STATUS_W-1:0] status);
         list_rsp_type want;
         results++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending, expected none actual %h %h %b %h",
                     $time, read_value, count, is_empty, status);
            return;
         end
         want = pending_rsp.pop_front();
         if (read_value !== want.read_value) report("read_value", want.read_value, read_value);
         if (count !== want.count) report("count", want.count, count);
         if (is_empty !== want.is_empty) report("is_empty", want.is_empty, is_empty);
         if (status !== want.status) report("status", want.status, status);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic [FUNC_W-1:0]       req_func = '0;
   logic [INDEX_W-1:0]      req_index = '0;
   logic [VALUE_W-1:0]      req_value = '0;
   logic                    rsp_ready = 1'b0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [VALUE_W-1:0]      rsp_read_value;
   logic [COUNT_PORT_W-1:0] rsp_count;
   logic                    rsp_is_empty;
   logic [STATUS_W-1:0]     rsp_status;

   list_scoreboard sb;
   list_mode_type  mode = MODE_GROW;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             phase_items = 0;

   indexed_list_insert_erase_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_read_value, rsp_count, rsp_is_empty, rsp_status);
   end

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [INDEX_W-1:0] index,
                               input logic [VALUE_W-1:0] value);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_index = index;
      req_value = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(func, index, value);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      int r;
      int pick;
      case (mode)
         MODE_GROW: begin
            if (sb.fill == DEPTH && $urandom_range(0, 15) == 0) mode = MODE_SHRINK;
         end
         MODE_SHRINK: begin
            if (sb.fill == 0) mode = ($urandom_range(0, 1) != 0) ? MODE_GROW : MODE_MIXED;
         end
         default: begin
            if ($urandom_range(0, 79) == 0)
               mode = ($urandom_range(0, 1) != 0) ? MODE_GROW : MODE_SHRINK;
         end
      endcase
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW:
            func = (r < 45) ? FUNC_APPEND : (r < 75) ? FUNC_INSERT :
                   (r < 85) ? FUNC_READ : (r < 93) ? FUNC_OVERWRITE : FUNC_ERASE;
         MODE_SHRINK:
            func = (r < 60) ? FUNC_ERASE : (r < 72) ? FUNC_READ :
                   (r < 80) ? FUNC_OVERWRITE : (r < 86) ? FUNC_APPEND :
                   (r < 92) ? FUNC_INSERT : (r < 94) ? FUNC_CLEAR :
                   (r < 97) ? FUNC_SPARE_6 : FUNC_SPARE_7;
         default:
            func = (r < 18) ? FUNC_APPEND : (r < 36) ? FUNC_READ :
                   (r < 52) ? FUNC_OVERWRITE : (r < 70) ? FUNC_INSERT :
                   (r < 91) ? FUNC_ERASE : (r < 94) ? FUNC_CLEAR :
                   (r < 97) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      endcase
      // mostly near or inside the held range, sometimes anywhere
      if ($urandom_range(0, 99) < 80) begin
         pick = $urandom_range(0, sb.fill);
         if (pick > 255) pick = 255;
         index = pick[INDEX_W-1:0];
      end else begin
         index = INDEX_W'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 9);
      value = (r == 0) ? '1 : (r == 1) ? '0 : $urandom;
      send_request(func, index, value);
      if (func <= FUNC_CLEAR) phase_items++;
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // empty list edges, then a short list exercised at both ends
      send_request(FUNC_READ, 8'd0, 32'h0);
      send_request(FUNC_OVERWRITE, 8'd0, 32'hFFFF_FFFF);
      send_request(FUNC_ERASE, 8'd255, 32'h0);
      send_request(FUNC_INSERT, 8'd1, 32'h1111_1111);
      send_request(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF);
      send_request(FUNC_APPEND, 8'd255, 32'h0);
      send_request(FUNC_APPEND, 8'd0, 32'hA5A5_A5A5);
      send_request(FUNC_INSERT, 8'd3, 32'h5A5A_5A5A);
      send_request(FUNC_INSERT, 8'd1, 32'h1234_5678);
      for (int k = 0; k < 6; k++) send_request(FUNC_READ, 8'(k), 32'hFFFF_FFFF);
      send_request(FUNC_OVERWRITE, 8'd4, 32'h8000_0001);
      send_request(FUNC_ERASE, 8'd0, 32'h0);
      send_request(FUNC_ERASE, 8'd3, 32'h0);
      send_request(FUNC_ERASE, 8'd4, 32'h0);
      send_request(FUNC_SPARE_6, 8'd0, 32'hDEAD_BEEF);
      send_request(FUNC_SPARE_7, 8'd255, 32'hFFFF_FFFF);
      send_request(FUNC_READ, 8'd1, 32'h0);
      send_request(FUNC_CLEAR, 8'd0, 32'h0);
      send_request(FUNC_READ, 8'd0, 32'h0);
      send_request(FUNC_APPEND, 8'd0, 32'h0000_0001);
      wait_for_drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) random_request();
         // hold off until every result beat is back
         wait_for_drain();
      end

      repeat (20) @(posedge clock);
      $display("run covered %0d request beats and %0d result beats, list filled %0d times",
               sb.requests, sb.results, sb.n_full_reached);
      $display("out-of-range rejects %0d, full rejects %0d, mismatches %0d",
               sb.n_range, sb.n_full, sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS indexed_list_insert_erase_unit");
      end else begin
         $display("FAIL indexed_list_insert_erase_unit");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL indexed_list_insert_erase_unit");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/ilie_pkg.sv
rtl/core/ilie_cell.sv
rtl/core/ilie_chain.sv
rtl/core/ilie_or_tree.sv
rtl/core/indexed_list_insert_erase_unit.sv
rtl/core/ilie_checker.sv
dv/indexed_list_insert_erase_unit_tb.sv
